// ===== src/npt_pkg.sv =====
`timescale 1ns / 1ps
package npt_pkg;

  localparam int NODE_SLOTS_DEF = 16;

  localparam logic [31:0] TIMEOUT_RST  = 32'd10000;
  localparam logic [4:0]  CAPACITY_RST = 5'd16;

  // register indexes
  localparam logic REG_TIMEOUT  = 1'b0;
  localparam logic REG_CAPACITY = 1'b1;

  // input modes
  localparam logic [2:0] MODE_UPDATE = 3'd0;
  localparam logic [2:0] MODE_SWEEP  = 3'd1;
  localparam logic [2:0] MODE_LOOKUP = 3'd2;
  localparam logic [2:0] MODE_DUMP   = 3'd3;
  localparam logic [2:0] MODE_REMOVE = 3'd4;
  localparam logic [2:0] MODE_CLEAR  = 3'd5;

  // result kinds
  localparam logic [1:0] KIND_FINAL   = 2'd0;
  localparam logic [1:0] KIND_OFFLINE = 2'd1;
  localparam logic [1:0] KIND_RECORD  = 2'd2;

  // status codes
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_BACK     = 3'd1;
  localparam logic [2:0] ST_REFRESH  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_FOUND    = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;
  localparam logic [2:0] ST_DONE     = 3'd6;

  typedef struct packed {
    logic [15:0]       addr;
    logic [31:0]       seen;
    logic signed [7:0] strength;
    logic              online;
  } entry_t;

endpackage

// ===== src/neighbor_presence_table.sv =====
`timescale 1ns / 1ps
// a lookup or update walks the table until the address is found; a miss walks every entry;
// a new address on a full table walks twice, remove then shifts every later entry down by one
// one item at a time: s_tready is high only in idle, which is entered once the last result
// is loaded; a sweep walks twice, one offline event per expired entry; a dump, one per entry
// reset: table empty, silence limit 10000 ms, capacity 16; table memory is not cleared
module neighbor_presence_table #(
  parameter int NODE_SLOTS = npt_pkg::NODE_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // node_addr[15:0], signal_strength[23:16], now_ms[55:24]
  input  logic [2:0]  s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], became_online[3], out_addr[19:4], out_last_seen[51:20],
  // out_strength[59:52], out_online[60], entry_count[65:61], online_count[70:66], zero[71]
  output logic [71:0] m_tdata,
  output logic [1:0]  m_tuser,   // result_kind
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import npt_pkg::*;

  localparam int IW   = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
  localparam int CW   = $clog2(NODE_SLOTS + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_EV    = 3'd2;
  localparam logic [2:0] S_FIN   = 3'd3;
  localparam logic [2:0] S_SH_RD = 3'd4;
  localparam logic [2:0] S_SH_WR = 3'd5;

  localparam logic [2:0] P_FIND  = 3'd0;
  localparam logic [2:0] P_REPL  = 3'd1;
  localparam logic [2:0] P_CNT   = 3'd2;
  localparam logic [2:0] P_SWEEP = 3'd3;
  localparam logic [2:0] P_DUMP  = 3'd4;

  entry_t mem [NODE_SLOTS];
  entry_t rdata;
  logic   rd_en;
  logic [IW-1:0] rd_idx;
  logic   wr_en;
  logic   wr_go;
  logic [IW-1:0] wr_idx;
  entry_t wr_data;

  logic [31:0] silence_limit;
  logic [4:0]  capacity;

  logic [2:0]  state;
  logic [2:0]  phase;
  logic [CW-1:0] ptr;
  logic [CW-1:0] ptr_inc;
  logic [CW-1:0] used_cnt;
  logic [CW-1:0] online_cnt;
  logic [CW-1:0] off_cnt;

  logic [2:0]  mode_r;
  logic [15:0] addr_r;
  logic signed [7:0] str_r;
  logic [31:0] now_r;

  logic        best_found;
  logic [31:0] best_seen;
  logic [IW-1:0] best_idx;

  logic [1:0]  res_kind;
  logic [2:0]  res_status;
  logic        res_became;
  entry_t      res_entry;
  logic        res_last;

  logic   out_free;
  logic   table_full;
  logic   expired;
  entry_t new_ent;
  entry_t miss_ent;

  assign pready   = 1'b1;
  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign ptr_inc  = ptr + CW'(1);

  assign table_full = (CMPW'(used_cnt) >= CMPW'(capacity)) || (used_cnt == CW'(NODE_SLOTS));
  assign expired    = rdata.online && ((now_r - rdata.seen) > silence_limit);
  assign new_ent    = '{addr: addr_r, seen: now_r, strength: str_r, online: 1'b1};
  assign miss_ent   = '{addr: addr_r, seen: 32'd0, strength: 8'sd0, online: 1'b0};

  assign rd_en  = ((state == S_RD) || (state == S_SH_RD)) && (ptr < used_cnt);
  assign rd_idx = (state == S_SH_RD) ? ptr_inc[IW-1:0] : ptr[IW-1:0];

  // table write decided by wr_go; wr_en, wr_idx and wr_data are registered before mem is written
  assign wr_go = ((state == S_RD) && !(ptr < used_cnt) &&
                  (((phase == P_FIND) && (mode_r == MODE_UPDATE) && !table_full) ||
                   ((phase == P_REPL) && best_found))) ||
                 ((state == S_EV) && (phase == P_FIND) && (rdata.addr == addr_r) &&
                  (mode_r == MODE_UPDATE)) ||
                 ((state == S_EV) && (phase == P_SWEEP) && expired) ||
                 (state == S_SH_WR);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_idx];
    end
  end

  always_comb begin
    prdata = 32'd0;
    case (paddr[2])
      REG_TIMEOUT:  prdata = silence_limit;
      REG_CAPACITY: prdata = {27'd0, capacity};
      default:      prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      silence_limit <= TIMEOUT_RST;
      capacity      <= CAPACITY_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_TIMEOUT:  silence_limit <= pwdata;
        REG_CAPACITY: capacity      <= pwdata[4:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= P_FIND;
      ptr        <= '0;
      used_cnt   <= '0;
      online_cnt <= '0;
      off_cnt    <= '0;
      best_found <= 1'b0;
      wr_en      <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      wr_en <= wr_go;
      if ((state == S_FIN) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            addr_r     <= s_tdata[15:0];
            str_r      <= s_tdata[23:16];
            now_r      <= s_tdata[55:24];
            mode_r     <= s_tuser;
            ptr        <= '0;
            off_cnt    <= '0;
            best_found <= 1'b0;
            res_kind   <= KIND_FINAL;
            res_status <= ST_DONE;
            res_became <= 1'b0;
            res_entry  <= '0;
            res_last   <= 1'b1;
            case (s_tuser)
              MODE_UPDATE, MODE_LOOKUP, MODE_REMOVE: begin
                phase <= P_FIND;
                state <= S_RD;
              end
              MODE_SWEEP: begin
                phase <= P_CNT;
                state <= S_RD;
              end
              MODE_DUMP: begin
                phase <= P_DUMP;
                state <= S_RD;
              end
              MODE_CLEAR: begin
                used_cnt   <= '0;
                online_cnt <= '0;
                state      <= S_FIN;
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_RD: begin
          if (ptr < used_cnt) begin
            state <= S_EV;
          end else begin
            case (phase)
              P_FIND: begin
                if ((mode_r == MODE_UPDATE) && table_full) begin
                  phase <= P_REPL;
                  ptr   <= '0;
                  state <= S_RD;
                end else if (mode_r == MODE_UPDATE) begin
                  wr_idx     <= used_cnt[IW-1:0];
                  wr_data    <= new_ent;
                  used_cnt   <= used_cnt + CW'(1);
                  online_cnt <= online_cnt + CW'(1);
                  res_kind   <= KIND_FINAL;
                  res_status <= ST_INSERTED;
                  res_became <= 1'b1;
                  res_entry  <= new_ent;
                  res_last   <= 1'b1;
                  state      <= S_FIN;
                end else begin
                  res_kind   <= KIND_FINAL;
                  res_status <= ST_NOTFOUND;
                  res_became <= 1'b0;
                  res_entry  <= miss_ent;
                  res_last   <= 1'b1;
                  state      <= S_FIN;
                end
              end
              P_REPL: begin
                res_kind <= KIND_FINAL;
                res_last <= 1'b1;
                state    <= S_FIN;
                if (best_found) begin
                  wr_idx     <= best_idx;
                  wr_data    <= new_ent;
                  online_cnt <= online_cnt + CW'(1);
                  res_status <= ST_INSERTED;
                  res_became <= 1'b1;
                  res_entry  <= new_ent;
                end else begin
                  res_status <= ST_FULL;
                  res_became <= 1'b0;
                  res_entry  <= miss_ent;
                end
              end
              P_CNT: begin
                // events carry the count after the whole sweep
                online_cnt <= online_cnt - off_cnt;
                phase      <= P_SWEEP;
                ptr        <= '0;
                state      <= S_RD;
              end
              default: begin
                res_kind   <= KIND_FINAL;
                res_status <= ST_DONE;
                res_became <= 1'b0;
                res_entry  <= '0;
                res_last   <= 1'b1;
                state      <= S_FIN;
              end
            endcase
          end
        end
        S_EV: begin
          case (phase)
            P_FIND: begin
              if (rdata.addr == addr_r) begin
                res_kind <= KIND_FINAL;
                res_last <= 1'b1;
                case (mode_r)
                  MODE_UPDATE: begin
                    wr_idx     <= ptr[IW-1:0];
                    wr_data    <= '{addr: rdata.addr, seen: now_r, strength: str_r,
                                    online: 1'b1};
                    res_entry  <= '{addr: rdata.addr, seen: now_r, strength: str_r,
                                    online: 1'b1};
                    res_status <= rdata.online ? ST_REFRESH : ST_BACK;
                    res_became <= !rdata.online;
                    if (!rdata.online) begin
                      online_cnt <= online_cnt + CW'(1);
                    end
                    state      <= S_FIN;
                  end
                  MODE_LOOKUP: begin
                    res_entry  <= rdata;
                    res_status <= ST_FOUND;
                    res_became <= 1'b0;
                    state      <= S_FIN;
                  end
                  default: begin
                    res_entry  <= rdata;
                    res_status <= ST_FOUND;
                    res_became <= 1'b0;
                    used_cnt   <= used_cnt - CW'(1);
                    online_cnt <= online_cnt - CW'(rdata.online);
                    state      <= S_SH_RD;
                  end
                endcase
              end else begin
                ptr   <= ptr_inc;
                state <= S_RD;
              end
            end
            P_REPL: begin
              ptr   <= ptr_inc;
              state <= S_RD;
              if (!rdata.online && (!best_found || rdata.seen < best_seen)) begin
                best_found <= 1'b1;
                best_seen  <= rdata.seen;
                best_idx   <= ptr[IW-1:0];
              end
            end
            P_CNT: begin
              ptr   <= ptr_inc;
              state <= S_RD;
              if (expired) begin
                off_cnt <= off_cnt + CW'(1);
              end
            end
            P_SWEEP: begin
              if (expired) begin
                wr_idx     <= ptr[IW-1:0];
                wr_data    <= '{addr: rdata.addr, seen: rdata.seen,
                                strength: rdata.strength, online: 1'b0};
                res_kind   <= KIND_OFFLINE;
                res_status <= ST_INSERTED;
                res_became <= 1'b0;
                res_entry  <= '{addr: rdata.addr, seen: rdata.seen,
                                strength: rdata.strength, online: 1'b0};
                res_last   <= 1'b0;
                state      <= S_FIN;
              end else begin
                ptr   <= ptr_inc;
                state <= S_RD;
              end
            end
            default: begin
              res_kind   <= KIND_RECORD;
              res_status <= ST_INSERTED;
              res_became <= 1'b0;
              res_entry  <= rdata;
              res_last   <= 1'b0;
              state      <= S_FIN;
            end
          endcase
        end
        S_SH_RD: begin
          // used_cnt already holds the count after removal
          if (ptr < used_cnt) begin
            state <= S_SH_WR;
          end else begin
            state <= S_FIN;
          end
        end
        S_SH_WR: begin
          wr_idx  <= ptr[IW-1:0];
          wr_data <= rdata;
          ptr     <= ptr_inc;
          state   <= S_SH_RD;
        end
        S_FIN: begin
          if (out_free) begin
            m_tuser  <= res_kind;
            m_tlast  <= res_last;
            m_tdata  <= {1'b0, 5'(online_cnt), 5'(used_cnt), res_entry.online,
                         res_entry.strength, res_entry.seen, res_entry.addr,
                         res_became, res_status};
            if (res_last) begin
              state <= S_IDLE;
            end else begin
              ptr   <= ptr_inc;
              state <= S_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
